// File: rtl/core/bpfm_pkg.sv
// Package for the buffer pool frame manager: payload structs, request codes,
// status codes, config indices, the pin limit and sequencer states. No dependencies.
package bpfm_pkg;

    localparam logic [1:0] KIND_PIN   = 2'd0;
    localparam logic [1:0] KIND_UNPIN = 2'd1;
    localparam logic [1:0] KIND_DIRTY = 2'd2;
    localparam logic [1:0] KIND_FORCE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_VICT  = 2'd1;
    localparam logic [1:0] ST_NOT_RES  = 2'd2;

    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    localparam logic [15:0] PIN_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] page_number;
    } req_t;

    typedef struct packed {
        logic [3:0]  frame;
        logic        hit;
        logic        read_valid;
        logic [30:0] read_page;
        logic        write_valid;
        logic [30:0] write_page;
        logic [1:0]  status;
        logic [31:0] read_count;
        logic [31:0] write_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOKUP, S_VICTIM, S_UPDATE, S_RESP
    } state_t;

endpackage

// File: rtl/core/buffer_pool_frame_manager.sv
// Top level of the buffer pool frame manager: frame table, scan sequencer
// and result register. Depends on bpfm_pkg.
//
// One request occupies the block from acceptance until its result beat is
// taken. After the accepting edge the shared frame comparator steps one
// frame per cycle: a lookup pass over the frames in use (after clamping),
// then, only for a pin that misses with no empty frame, a victim pass
// (FIFO stops at the first unpinned frame, LRU always walks all of them),
// then the update state and the result state. s_ready is high only in idle
// with no result waiting and the FIFO pointer below the frames in use, so
// a new request is taken only after the last result beat has gone. After a
// change of frames_in_use the FIFO pointer is brought below the new count
// by repeated subtraction while idle, holding s_ready low meanwhile. The
// result beat holds in m_* until taken, and reset needs no clearing pass.
module buffer_pool_frame_manager #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bpfm_pkg::req_t       s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bpfm_pkg::rsp_t       m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [4:0]           cfg_data
);
    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);

    logic          valid_reg [NUM_FRAMES];
    logic          dirty_reg [NUM_FRAMES];
    logic [15:0]   pin_reg   [NUM_FRAMES];
    logic [31:0]   stamp_reg [NUM_FRAMES];
    logic [30:0]   page_reg  [NUM_FRAMES];

    bpfm_pkg::state_t state_reg, state_next;
    bpfm_pkg::req_t   req_reg;
    bpfm_pkg::rsp_t   rsp_reg, rsp_next;
    logic             mode_reg;
    logic [4:0]       fiu_reg;
    logic [IW-1:0]    idx_reg, ptr_reg, start_reg;
    logic [CW-1:0]    cnt_reg, n_act;
    logic             found_reg, empty_ok_reg, vic_ok_reg;
    logic [IW-1:0]    found_idx_reg, empty_idx_reg, vic_idx_reg;
    logic [IW-1:0]    sel_idx;
    logic [31:0]      acc_reg, rd_cnt_reg, wr_cnt_reg;
    logic             ptr_high;

    // Clamp the frame count: zero acts as one, overrange as the pool size.
    always_comb begin
        if (fiu_reg == 5'd0)
            n_act = CW'(1);
        else if (32'(fiu_reg) > NUM_FRAMES)
            n_act = CW'(NUM_FRAMES);
        else
            n_act = CW'(fiu_reg);
    end

    // Pointer not yet reduced below the frames in use: hold the input.
    assign ptr_high  = (CW'(ptr_reg) >= n_act);
    assign s_ready   = (state_reg == bpfm_pkg::S_IDLE) && !m_valid && !ptr_high;
    assign cfg_ready = 1'b1;
    assign m_data    = rsp_reg;

    // Index of the frame the shared comparator looks at this cycle.
    logic [IW-1:0] cur;
    logic [CW:0]   fifo_sum;
    always_comb begin
        fifo_sum = (CW+1)'(start_reg) + (CW+1)'(cnt_reg);
        if (state_reg == bpfm_pkg::S_VICTIM && !mode_reg) begin
            if (fifo_sum >= (CW+1)'(n_act))
                cur = IW'(fifo_sum - (CW+1)'(n_act));
            else
                cur = IW'(fifo_sum);
        end else begin
            cur = idx_reg;
        end
    end

    logic last;
    assign last = (cnt_reg == n_act - CW'(1));

    // Result of the request, built from the scan outcome and the frame table.
    always_comb begin
        sel_idx  = empty_ok_reg ? empty_idx_reg : vic_idx_reg;
        rsp_next = '0;
        if (req_reg.kind == bpfm_pkg::KIND_PIN) begin
            if (found_reg) begin
                rsp_next.hit   = 1'b1;
                rsp_next.frame = 4'(found_idx_reg);
            end else if (empty_ok_reg || vic_ok_reg) begin
                if (!empty_ok_reg && dirty_reg[sel_idx]) begin
                    rsp_next.write_valid = 1'b1;
                    rsp_next.write_page  = page_reg[sel_idx];
                end
                rsp_next.read_valid = 1'b1;
                rsp_next.read_page  = req_reg.page_number;
                rsp_next.frame      = 4'(sel_idx);
            end else begin
                rsp_next.status = bpfm_pkg::ST_NO_VICT;
            end
        end else if (!found_reg) begin
            rsp_next.status = bpfm_pkg::ST_NOT_RES;
        end else begin
            rsp_next.frame = 4'(found_idx_reg);
            if (req_reg.kind == bpfm_pkg::KIND_FORCE) begin
                rsp_next.write_valid = 1'b1;
                rsp_next.write_page  = page_reg[found_idx_reg];
            end
        end
        // Counters include this request's own read and write back.
        rsp_next.read_count  = rd_cnt_reg + 32'(rsp_next.read_valid);
        rsp_next.write_count = wr_cnt_reg + 32'(rsp_next.write_valid);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpfm_pkg::S_IDLE:
                if (s_valid && s_ready) state_next = bpfm_pkg::S_LOOKUP;
            bpfm_pkg::S_LOOKUP:
                if (last) begin
                    if (req_reg.kind == bpfm_pkg::KIND_PIN && !found_reg
                        && !(valid_reg[cur] && page_reg[cur] == req_reg.page_number)
                        && !empty_ok_reg && valid_reg[cur])
                        state_next = bpfm_pkg::S_VICTIM;
                    else
                        state_next = bpfm_pkg::S_UPDATE;
                end
            bpfm_pkg::S_VICTIM:
                if (last || (!mode_reg && pin_reg[cur] == 16'd0))
                    state_next = bpfm_pkg::S_UPDATE;
            bpfm_pkg::S_UPDATE: state_next = bpfm_pkg::S_RESP;
            bpfm_pkg::S_RESP:   state_next = bpfm_pkg::S_IDLE;
            default:            state_next = bpfm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bpfm_pkg::S_IDLE;
            m_valid    <= 1'b0;
            mode_reg   <= 1'b0;
            fiu_reg    <= 5'd16;
            ptr_reg    <= '0;
            acc_reg    <= '0;
            rd_cnt_reg <= '0;
            wr_cnt_reg <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
                pin_reg[i]   <= '0;
                stamp_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cfg_valid) begin
                if (cfg_index == bpfm_pkg::CFG_MODE) mode_reg <= cfg_data[0];
                else                                 fiu_reg  <= cfg_data;
            end
            case (state_reg)
                bpfm_pkg::S_IDLE:
                    if (ptr_high) begin
                        // Reduce the pointer modulo the frames in use.
                        ptr_reg <= IW'(CW'(ptr_reg) - n_act);
                    end else if (s_valid && s_ready) begin
                        req_reg      <= s_data;
                        idx_reg      <= '0;
                        cnt_reg      <= '0;
                        found_reg    <= 1'b0;
                        empty_ok_reg <= 1'b0;
                        vic_ok_reg   <= 1'b0;
                        start_reg    <= ptr_reg;
                    end
                bpfm_pkg::S_LOOKUP: begin
                    if (!found_reg && valid_reg[cur]
                        && page_reg[cur] == req_reg.page_number) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= cur;
                    end
                    if (!empty_ok_reg && !valid_reg[cur]) begin
                        empty_ok_reg  <= 1'b1;
                        empty_idx_reg <= cur;
                    end
                    idx_reg <= last ? '0 : cur + IW'(1);
                    cnt_reg <= last ? '0 : cnt_reg + CW'(1);
                end
                bpfm_pkg::S_VICTIM: begin
                    // Keep the first unpinned frame (FIFO) or the oldest (LRU).
                    if (pin_reg[cur] == 16'd0 && (!vic_ok_reg
                        || (mode_reg && stamp_reg[cur] < stamp_reg[vic_idx_reg]))) begin
                        vic_ok_reg  <= 1'b1;
                        vic_idx_reg <= cur;
                    end
                    idx_reg <= cur + IW'(1);
                    cnt_reg <= cnt_reg + CW'(1);
                end
                bpfm_pkg::S_UPDATE: begin
                    rsp_reg    <= rsp_next;
                    rd_cnt_reg <= rsp_next.read_count;
                    wr_cnt_reg <= rsp_next.write_count;
                    if (req_reg.kind == bpfm_pkg::KIND_PIN) begin
                        if (found_reg) begin
                            if (pin_reg[found_idx_reg] != bpfm_pkg::PIN_MAX)
                                pin_reg[found_idx_reg] <= pin_reg[found_idx_reg] + 16'd1;
                            acc_reg <= acc_reg + 32'd1;
                            stamp_reg[found_idx_reg] <= acc_reg + 32'd1;
                        end else if (empty_ok_reg || vic_ok_reg) begin
                            valid_reg[sel_idx] <= 1'b1;
                            page_reg[sel_idx]  <= req_reg.page_number;
                            dirty_reg[sel_idx] <= 1'b0;
                            pin_reg[sel_idx]   <= 16'd1;
                            acc_reg            <= acc_reg + 32'd1;
                            stamp_reg[sel_idx] <= acc_reg + 32'd1;
                            ptr_reg <= (CW'(start_reg) + CW'(1) >= n_act)
                                       ? '0 : start_reg + IW'(1);
                        end
                    end else if (found_reg) begin
                        case (req_reg.kind)
                            bpfm_pkg::KIND_UNPIN:
                                if (pin_reg[found_idx_reg] != 16'd0)
                                    pin_reg[found_idx_reg] <= pin_reg[found_idx_reg] - 16'd1;
                            bpfm_pkg::KIND_DIRTY: dirty_reg[found_idx_reg] <= 1'b1;
                            default: dirty_reg[found_idx_reg] <= 1'b0;
                        endcase
                    end
                end
                bpfm_pkg::S_RESP: begin
                    m_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == bpfm_pkg::S_IDLE)
        else $error("ready outside idle");
    a_resp_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bpfm_pkg::S_RESP |=> m_valid)
        else $error("result not presented");
    a_read_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.read_valid |-> m_data.read_page == 31'd0)
        else $error("stray read page");
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> m_data.status == bpfm_pkg::ST_OK && !m_data.read_valid)
        else $error("hit with read");
endmodule
